// ----- rtl/core/dbra_pkg.sv -----
package dbra_pkg;

	localparam int BYTE_W     = 8;
	localparam int REG_W      = 11;
	localparam int REG_IDX_W  = 1;
	localparam int CNT_OUT_W  = 11;
	localparam int RUN_W      = 14;
	localparam int HIST_DEPTH = 256;
	localparam int HIST_AW    = 8;

	localparam logic [REG_W-1:0] MAX_BYTES_RESET  = 11'd1000;
	localparam logic [REG_W-1:0] MIN_REGION_RESET = 11'd100;

	localparam logic [REG_IDX_W-1:0] REG_MAX_BYTES  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_REGION = 1'b1;

	typedef struct packed {
		logic load;
		logic hscan_start;
		logic hist_rd;
		logic store_rd;
		logic win_clear;
	} dbra_cmd_t;

	typedef struct packed {
		logic hist_end;
		logic store_end;
	} dbra_status_t;

endpackage

// ----- rtl/core/dbra_ctrl.sv -----
module dbra_ctrl
	import dbra_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         last,
	input  dbra_status_t status,
	output dbra_cmd_t    cmd,
	output logic         busy,
	output logic         done
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DRAIN = 5'b00010,
		S_HIST  = 5'b00100,
		S_STORE = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start && last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd.hscan_start = 1'b1;
				state_d         = S_HIST;
			end
			S_HIST: begin
				cmd.hist_rd = 1'b1;
				if (status.hist_end) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store_rd = !status.store_end;
				if (status.store_end) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				cmd.win_clear = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);

endmodule

// ----- rtl/core/dbra_datapath.sv -----
module dbra_datapath
	import dbra_pkg::*;
#(
	parameter int STORE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dbra_cmd_t            cmd,
	output dbra_status_t         status,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic [BYTE_W-1:0]    data_byte,
	output logic [BYTE_W-1:0]    peak_byte,
	output logic [CNT_OUT_W-1:0] match_count,
	output logic [CNT_OUT_W-1:0] byte_count,
	output logic [RUN_W-1:0]     run_bits
);

	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int XW = (CW > REG_W) ? CW : REG_W;

	logic [REG_W-1:0] max_bytes_q, min_region_q;
	logic [CW-1:0]    kept_q;

	logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
	logic [BYTE_W-1:0] store_rd_s1;
	logic              store_we;

	logic [CW-1:0]           hist_mem [HIST_DEPTH];
	logic [HIST_DEPTH-1:0]   hist_vld_q;
	logic [CW-1:0]           hist_rd_s1;
	logic                    hist_vld_s1;
	logic [HIST_AW-1:0]      hist_raddr;
	logic [CW-1:0]           hist_val;
	logic [CW-1:0]           hist_base;
	logic [CW-1:0]           hist_new;

	logic              keep;
	logic              ld_s1, ld_s2;
	logic [BYTE_W-1:0] b_s1, b_s2;
	logic [CW-1:0]     val_s2;

	logic [HIST_AW-1:0] hidx_q, hidx_s1;
	logic               hvalid_s1;
	logic [CW-1:0]      sidx_q;
	logic               svalid_s1;

	logic [BYTE_W-1:0] best_q;
	logic [CW-1:0]     best_cnt_q;
	logic [CW-1:0]     match_q;
	logic [CW-1:0]     run_q;
	logic              stop_q;
	logic              eq;
	logic              run_hit;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q  <= MAX_BYTES_RESET;
			min_region_q <= MIN_REGION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_BYTES:  max_bytes_q  <= cfg_data;
				REG_MIN_REGION: min_region_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign keep = (kept_q < CW'(STORE_DEPTH)) && (XW'(kept_q) < XW'(max_bytes_q));
	assign store_we = cmd.load && keep;

	// byte store
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[kept_q[AW-1:0]] <= data_byte;
		end
		if (cmd.store_rd) begin
			store_rd_s1 <= store_mem[sidx_q[AW-1:0]];
		end
	end

	// histogram memory, registered read then write, with the previous update forwarded
	assign hist_raddr = cmd.load ? data_byte : hidx_q;
	assign hist_val   = hist_vld_s1 ? hist_rd_s1 : '0;
	assign hist_base  = (ld_s2 && (b_s2 == b_s1)) ? val_s2 : hist_val;
	assign hist_new   = hist_base + CW'(1);

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			hist_mem[b_s1] <= hist_new;
		end
		if (cmd.load || cmd.hist_rd) begin
			hist_rd_s1  <= hist_mem[hist_raddr];
			hist_vld_s1 <= hist_vld_q[hist_raddr];
		end
		b_s1    <= data_byte;
		b_s2    <= b_s1;
		val_s2  <= hist_new;
		hidx_s1 <= hidx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			kept_q     <= '0;
			ld_s1      <= 1'b0;
			ld_s2      <= 1'b0;
		end else begin
			ld_s1 <= store_we;
			ld_s2 <= ld_s1;
			if (cmd.win_clear) begin
				hist_vld_q <= '0;
				kept_q     <= '0;
			end else begin
				if (ld_s1) begin
					hist_vld_q[b_s1] <= 1'b1;
				end
				if (store_we) begin
					kept_q <= kept_q + CW'(1);
				end
			end
		end
	end

	// post-pass scans
	assign eq      = (store_rd_s1 == best_q);
	assign run_hit = XW'(run_q) > XW'(min_region_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidx_q     <= '0;
			sidx_q     <= '0;
			hvalid_s1  <= 1'b0;
			svalid_s1  <= 1'b0;
			best_q     <= '0;
			best_cnt_q <= '0;
			match_q    <= '0;
			run_q      <= '0;
			stop_q     <= 1'b0;
		end else begin
			hvalid_s1 <= cmd.hist_rd;
			svalid_s1 <= cmd.store_rd;
			if (cmd.hscan_start) begin
				hidx_q     <= '0;
				sidx_q     <= '0;
				best_q     <= '0;
				best_cnt_q <= '0;
				match_q    <= '0;
				run_q      <= '0;
				stop_q     <= 1'b0;
			end else begin
				if (cmd.hist_rd) begin
					hidx_q <= hidx_q + HIST_AW'(1);
				end
				if (cmd.store_rd) begin
					sidx_q <= sidx_q + CW'(1);
				end
				if (hvalid_s1 && (hist_val > best_cnt_q)) begin
					best_cnt_q <= hist_val;
					best_q     <= hidx_s1;
				end
				if (svalid_s1) begin
					if (eq) begin
						match_q <= match_q + CW'(1);
					end
					if (!stop_q) begin
						if (eq) begin
							run_q <= run_q + CW'(1);
						end else if (run_hit) begin
							stop_q <= 1'b1;
						end else begin
							run_q <= '0;
						end
					end
				end
			end
		end
	end

	assign status.hist_end  = (hidx_q == HIST_AW'(HIST_DEPTH - 1));
	assign status.store_end = (sidx_q == kept_q);

	assign peak_byte   = best_q;
	assign match_count = CNT_OUT_W'(match_q);
	assign byte_count  = CNT_OUT_W'(kept_q);
	assign run_bits    = RUN_W'({run_q, 3'b000});

endmodule

// ----- rtl/core/dominant_byte_run_analyzer_unit.sv -----
// Takes one window byte per cycle while busy is low (start high), keeping
// the first max_bytes of them, at most STORE_DEPTH. After the byte marked
// last, busy stays high while a drain state lets the last histogram update
// land, the histogram memory is scanned through its single read port, the
// byte store is scanned through its read port, and in the final cycle done
// is high for exactly one cycle with peak_byte, match_count, byte_count and
// run_bits. The receiver cannot stall and must take the result in that cycle.
module dominant_byte_run_analyzer_unit
	import dbra_pkg::*;
#(
	parameter int STORE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 last,
	output logic                 done,
	output logic [BYTE_W-1:0]    peak_byte,
	output logic [CNT_OUT_W-1:0] match_count,
	output logic [CNT_OUT_W-1:0] byte_count,
	output logic [RUN_W-1:0]     run_bits
);

	dbra_cmd_t    cmd;
	dbra_status_t status;

	dbra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dbra_datapath #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_byte   (data_byte),
		.peak_byte   (peak_byte),
		.match_count (match_count),
		.byte_count  (byte_count),
		.run_bits    (run_bits)
	);

endmodule

// ----- dv/dominant_byte_run_analyzer_unit_tb.sv -----
`timescale 1ns / 1ps

module dominant_byte_run_analyzer_unit_tb
	import dbra_pkg::*;
;

	localparam int STORE_DEPTH = 1024;
	localparam int ITEM_TARGET = 1250;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [BYTE_W-1:0]    dominant;
		logic [CNT_OUT_W-1:0] hits;
		logic [CNT_OUT_W-1:0] kept;
		logic [RUN_W-1:0]     run_bits;
	} window_result_t;

	class window_scoreboard;
		logic [BYTE_W-1:0] kept_bytes[STORE_DEPTH];
		int unsigned       byte_tally[HIST_DEPTH];
		int unsigned       kept_total;
		logic [REG_W-1:0]  max_bytes;
		logic [REG_W-1:0]  min_region;
		window_result_t    expected_q[$];
		int unsigned       errors;
		int unsigned       windows_checked;

		function new();
			clear_window();
			max_bytes = MAX_BYTES_RESET;
			min_region = MIN_REGION_RESET;
			errors = 0;
			windows_checked = 0;
		endfunction

		function void clear_window();
			foreach (byte_tally[i]) byte_tally[i] = 0;
			kept_total = 0;
		endfunction

		function void set_register(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
			if (idx == REG_MAX_BYTES) begin
				max_bytes = val;
			end else if (idx == REG_MIN_REGION) begin
				min_region = val;
			end
		endfunction

		// returns whether the byte is kept for analysis
		function bit note_byte(logic [BYTE_W-1:0] b, logic is_last);
			int unsigned    cap;
			int unsigned    top;
			int unsigned    hit_total;
			int unsigned    run;
			bit             kept;
			window_result_t r;
			cap = (max_bytes > STORE_DEPTH) ? STORE_DEPTH : max_bytes;
			kept = (kept_total < cap);
			if (kept) begin
				kept_bytes[kept_total] = b;
				byte_tally[b]++;
				kept_total++;
			end
			if (is_last) begin
				top = 0;
				r.dominant = '0;
				for (int i = 0; i < HIST_DEPTH; i++) begin
					if (byte_tally[i] > top) begin
						top = byte_tally[i];
						r.dominant = BYTE_W'(i);
					end
				end
				hit_total = 0;
				for (int i = 0; i < kept_total; i++) begin
					if (kept_bytes[i] == r.dominant) hit_total++;
				end
				run = 0;
				for (int i = 0; i < kept_total; i++) begin
					if (kept_bytes[i] == r.dominant) begin
						run++;
					end else if (run > min_region) begin
						break;
					end else begin
						run = 0;
					end
				end
				r.hits = CNT_OUT_W'(hit_total);
				r.kept = CNT_OUT_W'(kept_total);
				r.run_bits = RUN_W'(run * 8);
				expected_q.push_back(r);
				clear_window();
			end
			return kept;
		endfunction

		function void check_window(window_result_t got);
			window_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with no window pending: dominant %0d hits %0d kept %0d run_bits %0d",
						got.dominant, got.hits, got.kept, got.run_bits);
				return;
			end
			want = expected_q.pop_front();
			windows_checked++;
			if (got.dominant !== want.dominant || got.hits !== want.hits ||
					got.kept !== want.kept || got.run_bits !== want.run_bits) begin
				errors++;
				if (errors <= 10) begin
					$display("window %0d expected: dominant %0d hits %0d kept %0d run_bits %0d",
						windows_checked, want.dominant, want.hits, want.kept, want.run_bits);
					$display("window %0d actual:   dominant %0d hits %0d kept %0d run_bits %0d",
						windows_checked, got.dominant, got.hits, got.kept, got.run_bits);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;
	logic                 start;
	logic                 busy;
	logic [BYTE_W-1:0]    data_byte;
	logic                 last;
	logic                 done;
	logic [BYTE_W-1:0]    peak_byte;
	logic [CNT_OUT_W-1:0] match_count;
	logic [CNT_OUT_W-1:0] byte_count;
	logic [RUN_W-1:0]     run_bits;

	window_scoreboard sb;
	int unsigned      cycle_count = 0;
	int unsigned      kept_items;
	int unsigned      bytes_sent;
	int unsigned      phase;

	dominant_byte_run_analyzer_unit #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.data_byte    (data_byte),
		.last         (last),
		.done         (done),
		.peak_byte    (peak_byte),
		.match_count  (match_count),
		.byte_count   (byte_count),
		.run_bits     (run_bits)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_window({peak_byte, match_count, byte_count, run_bits});
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("dominant_byte_run_analyzer_unit: mismatch");
			$finish;
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_register(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l, input bit idle_on);
		data_byte <= b;
		last <= l;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		bytes_sent++;
		if (sb.note_byte(b, l)) kept_items++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// wait for every pending window, then let the load pipeline drain
	task automatic settle();
		start <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_window(input int len, input bit idle_on);
		int                mode;
		int                nalpha;
		int                seg;
		logic [BYTE_W-1:0] alpha[4];
		logic [BYTE_W-1:0] val;
		mode = $urandom_range(0, 9);
		nalpha = $urandom_range(1, 4);
		foreach (alpha[k]) alpha[k] = BYTE_W'($urandom);
		seg = 0;
		val = alpha[0];
		for (int k = 0; k < len; k++) begin
			if (mode < 7) begin
				// runs over a small alphabet
				if (seg == 0) begin
					val = alpha[$urandom_range(0, nalpha - 1)];
					seg = $urandom_range(1, 12);
				end
				seg--;
			end else if (mode < 9) begin
				val = BYTE_W'($urandom);
			end else begin
				val = alpha[k % 2];
			end
			send_byte(val, k == len - 1, idle_on);
		end
	endtask

	initial begin
		int                len;
		int                nwin;
		bit                quiet;
		logic [BYTE_W-1:0] fill;
		sb = new();
		kept_items = 0;
		bytes_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		start = 1'b0;
		data_byte = '0;
		last = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// limit and tie: lowest value wins, trailing bytes past the limit
		write_reg(REG_MAX_BYTES, 11'd4);
		write_reg(REG_MIN_REGION, 11'd1);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hA5, 1'b1, 1'b0);
		// register change within a window
		send_byte(8'h3C, 1'b0, 1'b0);
		send_byte(8'h3C, 1'b0, 1'b0);
		settle();
		write_reg(REG_MAX_BYTES, 11'd2);
		send_byte(8'h3C, 1'b0, 1'b0);
		send_byte(8'hC3, 1'b1, 1'b0);
		// nothing kept
		settle();
		write_reg(REG_MAX_BYTES, 11'd0);
		send_byte(8'h7E, 1'b0, 1'b0);
		send_byte(8'h81, 1'b1, 1'b0);
		// run ended by another byte above a zero threshold
		settle();
		write_reg(REG_MAX_BYTES, 11'd2047);
		write_reg(REG_MIN_REGION, 11'd0);
		send_byte(8'h11, 1'b0, 1'b1);
		send_byte(8'h22, 1'b0, 1'b1);
		send_byte(8'h22, 1'b0, 1'b1);
		send_byte(8'h11, 1'b0, 1'b1);
		send_byte(8'h22, 1'b0, 1'b1);
		send_byte(8'h22, 1'b0, 1'b1);
		send_byte(8'h22, 1'b1, 1'b1);

		phase = 0;
		while (bytes_sent + STORE_DEPTH + 6 < ITEM_TARGET) begin
			settle();
			case (phase % 7)
				0: begin
					write_reg(REG_MAX_BYTES, REG_W'($urandom_range(1, 48)));
					write_reg(REG_MIN_REGION, REG_W'($urandom_range(0, 6)));
				end
				1: begin
					write_reg(REG_MAX_BYTES, 11'd1024);
					write_reg(REG_MIN_REGION, REG_W'($urandom_range(0, 10)));
				end
				2: begin
					write_reg(REG_MAX_BYTES, 11'd2047);
					write_reg(REG_MIN_REGION, 11'd2047);
				end
				3: begin
					write_reg(REG_MAX_BYTES, REG_W'($urandom_range(0, 2047)));
					write_reg(REG_MIN_REGION, REG_W'($urandom_range(0, 2047)));
				end
				4: begin
					write_reg(REG_MAX_BYTES, 11'd1);
					write_reg(REG_MIN_REGION, 11'd0);
				end
				5: begin
					write_reg(REG_MAX_BYTES, REG_W'($urandom_range(1, 16)));
					write_reg(REG_MIN_REGION, 11'd1024);
				end
				default: begin
					write_reg(REG_MAX_BYTES,
						(phase == 6) ? '0 : REG_W'($urandom_range(8, 64)));
					write_reg(REG_MIN_REGION, REG_W'($urandom_range(0, 4)));
				end
			endcase
			quiet = (phase % 5 == 3);
			nwin = $urandom_range(2, 4);
			for (int w = 0; w < nwin && bytes_sent + STORE_DEPTH + 6 < ITEM_TARGET; w++) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
				send_window(len, !quiet);
			end
			phase++;
		end

		// one full store of a single value, a few bytes past the depth
		settle();
		write_reg(REG_MAX_BYTES, 11'd2047);
		write_reg(REG_MIN_REGION, REG_W'($urandom_range(0, 2047)));
		fill = BYTE_W'($urandom);
		for (int k = 0; k < STORE_DEPTH + 6; k++) begin
			send_byte(fill, k == STORE_DEPTH + 5, 1'b0);
		end

		start <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (STORE_DEPTH + 300) @(posedge clk);
		sb.errors += sb.expected_q.size();

		$display("covered %0d windows from %0d bytes (%0d kept) over %0d register settings",
			sb.windows_checked, bytes_sent, kept_items, phase + 5);
		$display("%0d result mismatches", sb.errors);
		if (sb.errors == 0) begin
			$display("dominant_byte_run_analyzer_unit: match");
		end else begin
			$display("dominant_byte_run_analyzer_unit: mismatch");
		end
		$finish;
	end

endmodule
